>>> hw/rtl/fqs_pkg.sv
//------------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants of the searchable FIFO queue.
//------------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic signed [WORD_W-1:0] EMPTY_READ = '1;

  // Depth of the command queue between the front and the back.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  typedef struct packed {
    logic                     is_enq;
    logic                     is_deq;
    logic                     is_search;
    logic                     is_clear;
    logic signed [WORD_W-1:0] value;
  } fqs_cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic                     found;
    logic                     was_empty;
    logic                     overflow;
    logic [COUNT_W-1:0]       item_count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
  } fqs_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/fqs_cmd_if.sv
//------------------------------------------------------------------------------
// fqs_cmd_if
// Command channel: one word carries an opcode and a value.
//------------------------------------------------------------------------------
`default_nettype none

interface fqs_cmd_if
  import fqs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fqs_rsp_if.sv
//------------------------------------------------------------------------------
// fqs_rsp_if
// Response channel: one word carries the result of one command.
//------------------------------------------------------------------------------
`default_nettype none

interface fqs_rsp_if
  import fqs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic                     found;
  logic                     was_empty;
  logic                     overflow;
  logic [COUNT_W-1:0]       item_count;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] rear_value;

  modport source (
    output valid, output read_value, output found, output was_empty,
    output overflow, output item_count, output front_value, output rear_value,
    input ready
  );
  modport sink (
    input valid, input read_value, input found, input was_empty,
    input overflow, input item_count, input front_value, input rear_value,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/fqs_front.sv
//------------------------------------------------------------------------------
// fqs_front
// Accepts command words, decodes the opcode and holds them in a short queue.
//------------------------------------------------------------------------------
`default_nettype none

module fqs_front
  import fqs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fqs_cmd_if.sink   cmd,
  output fqs_cmd_t  issue,
  output logic      issue_valid,
  input  wire logic issue_pop
);

  fqs_cmd_t         slots [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_CW-1:0] fill;
  logic             push;
  logic             pop;
  fqs_cmd_t         decoded;

  always_comb begin
    decoded           = '0;
    decoded.value     = cmd.value;
    decoded.is_enq    = (cmd.opcode == OP_ENQUEUE);
    decoded.is_deq    = (cmd.opcode == OP_DEQUEUE);
    decoded.is_search = (cmd.opcode == OP_SEARCH);
    decoded.is_clear  = (cmd.opcode == OP_CLEAR);
  end

  assign cmd.ready   = (fill != CQ_CW'(CQ_DEPTH));
  assign push        = cmd.valid && cmd.ready;
  assign issue_valid = (fill != '0);
  assign pop         = issue_pop && issue_valid;
  assign issue       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fqs_back.sv
//------------------------------------------------------------------------------
// fqs_back
// Executes queued commands on the ring store and registers the response word.
//------------------------------------------------------------------------------
`default_nettype none

module fqs_back
  import fqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  fqs_cmd_t  issue,
  input  wire logic issue_valid,
  output logic      issue_pop,
  fqs_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;
  logic [AW-1:0]            rd_addr;

  logic [1:0]               state;
  logic [AW-1:0]            head;
  logic [AW-1:0]            tail;
  logic [CW-1:0]            count;
  logic signed [WORD_W-1:0] front_word;
  logic signed [WORD_W-1:0] rear_word;
  logic signed [WORD_W-1:0] deq_word;
  logic signed [WORD_W-1:0] key;
  logic [AW-1:0]            scan_ptr;
  logic [CW-1:0]            scan_left;
  logic                     hit;

  logic                     out_free;
  logic                     start;
  logic                     full;
  logic                     empty;
  logic                     match;
  logic                     mem_we;
  logic [AW-1:0]            head_inc;
  logic                     out_set;
  fqs_rsp_t                 o;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    ring_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign out_free  = !rsp.valid || rsp.ready;
  assign start     = (state == ST_IDLE) && issue_valid && out_free;
  assign issue_pop = start;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign head_inc  = ring_next(head);
  assign match     = (rd_data == key);
  assign mem_we    = start && issue.is_enq && !full;
  assign rd_addr   = (state == ST_IDLE) ? (issue.is_deq ? head_inc : head) : scan_ptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= issue.value;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    out_set      = 1'b0;
    o            = '0;
    o.item_count = COUNT_W'(count);
    case (state)
      ST_IDLE: begin
        if (start) begin
          out_set = 1'b1;
          if (issue.is_enq) begin
            if (full) begin
              o.overflow    = 1'b1;
              o.front_value = front_word;
              o.rear_value  = rear_word;
            end else begin
              o.item_count  = COUNT_W'(count + 1'b1);
              o.front_value = empty ? issue.value : front_word;
              o.rear_value  = issue.value;
            end
          end else if (issue.is_deq) begin
            if (empty) begin
              o.read_value = EMPTY_READ;
              o.was_empty  = 1'b1;
            end else begin
              out_set = 1'b0;
            end
          end else if (issue.is_search) begin
            out_set = empty;
          end else begin
            o.item_count = '0;
          end
        end
      end
      ST_FETCH: begin
        out_set      = 1'b1;
        o.read_value = deq_word;
        if (!empty) begin
          o.front_value = rd_data;
          o.rear_value  = rear_word;
        end
      end
      ST_SCAN: begin
        if (scan_left == '0) begin
          out_set       = 1'b1;
          o.found       = hit || match;
          o.front_value = front_word;
          o.rear_value  = rear_word;
        end
      end
      default: begin
        out_set = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      rsp.read_value  <= o.read_value;
      rsp.found       <= o.found;
      rsp.was_empty   <= o.was_empty;
      rsp.overflow    <= o.overflow;
      rsp.item_count  <= o.item_count;
      rsp.front_value <= o.front_value;
      rsp.rear_value  <= o.rear_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_set) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (issue.is_enq) begin
              if (!full) begin
                tail      <= ring_next(tail);
                count     <= count + 1'b1;
                rear_word <= issue.value;
                if (empty) begin
                  front_word <= issue.value;
                end
              end
            end else if (issue.is_deq) begin
              if (!empty) begin
                head     <= head_inc;
                count    <= count - 1'b1;
                deq_word <= front_word;
                state    <= ST_FETCH;
              end
            end else if (issue.is_search) begin
              if (!empty) begin
                key       <= issue.value;
                hit       <= 1'b0;
                scan_ptr  <= head_inc;
                scan_left <= count - 1'b1;
                state     <= ST_SCAN;
              end
            end else begin
              head  <= '0;
              tail  <= '0;
              count <= '0;
            end
          end
        end
        ST_FETCH: begin
          front_word <= rd_data;
          state      <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_left == '0) begin
            state <= ST_IDLE;
          end else begin
            hit       <= hit || match;
            scan_ptr  <= ring_next(scan_ptr);
            scan_left <= scan_left - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fifo_queue_with_search.sv
//------------------------------------------------------------------------------
// fifo_queue_with_search
// Bounded FIFO queue of signed 32-bit words with enqueue, dequeue, search
// and clear commands; every command returns one response word.
//
//   channel | direction | carries
//   --------+-----------+-------------------------------------------------
//   cmd     | in        | opcode, value
//   rsp     | out       | read_value, found, was_empty, overflow,
//           |           | item_count, front_value, rear_value
//
// Enqueue, clear and any command on an empty queue complete in the idle
// state of the execution unit; a dequeue also passes through the fetch
// state, since the new front word is read from the store. A search walks
// the stored words in the scan state, one store read per stored word.
// A two-word command queue lets the input run ahead of the execution unit;
// a new command starts only once the response register is free or its word is taken.
// Reset is synchronous and empties the queue; no clearing pass is needed.
//------------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_search
  import fqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  fqs_cmd_if.sink   cmd,
  fqs_rsp_if.source rsp
);

  fqs_cmd_t issue;
  logic     issue_valid;
  logic     issue_pop;

  fqs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .issue       (issue),
    .issue_valid (issue_valid),
    .issue_pop   (issue_pop)
  );

  fqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_valid (issue_valid),
    .issue_pop   (issue_pop),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire
